>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: cond holds in the same cycle as trig.
`define ASSERT_IMPLY(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Next-cycle implication: cond holds in the cycle after trig.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> hdl/cssf_pkg.sv
// ----------------------------------------------------------------------------
// cssf_pkg
// Types and character constants shared by the comment strip filter.
// ----------------------------------------------------------------------------
package cssf_pkg;

	// Characters that steer the scan
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;

	// Result queue geometry
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	// Scan mode, one-hot
	typedef enum logic [3:0] {
		MODE_TEXT   = 4'b0001,
		MODE_STRING = 4'b0010,
		MODE_LINE   = 4'b0100,
		MODE_BLOCK  = 4'b1000
	} mode_t;

	// Scanner state carried from byte to byte
	typedef struct packed {
		mode_t      mode;
		logic [7:0] held_char;
		logic       held_present;
		logic [7:0] char_before_held;
	} scan_state_t;

	// One result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
		logic       unclosed_comment;
	} result_t;

	// Queue writes requested for one accepted byte
	typedef struct packed {
		logic push_a;
		logic push_b;
	} push_t;

	// Queue status toward the top level
	typedef struct packed {
		logic not_empty;
		logic room2;
	} queue_status_t;

endpackage

>>> hdl/cssf_scan.sv
// ----------------------------------------------------------------------------
// cssf_scan
// Judges the held byte against the incoming byte, and on the final byte
// judges that byte too; produces up to two results and the next state.
// ----------------------------------------------------------------------------
module cssf_scan (
	input  cssf_pkg::scan_state_t state,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output cssf_pkg::scan_state_t state_next,
	output cssf_pkg::push_t       push,
	output cssf_pkg::result_t     res_a,
	output cssf_pkg::result_t     res_b
);

	typedef struct packed {
		logic            keep;
		cssf_pkg::mode_t mode;
	} judge_t;

	// Decide whether c is kept and where the mode goes
	function automatic judge_t judge(input cssf_pkg::mode_t mode, input logic [7:0] c,
			input logic [7:0] prev, input logic has_next, input logic [7:0] nxt);
		judge_t j;
		j.keep = 1'b1;
		j.mode = mode;
		unique case (mode)
			cssf_pkg::MODE_STRING: begin
				if (c == cssf_pkg::CH_QUOTE) j.mode = cssf_pkg::MODE_TEXT;
			end
			cssf_pkg::MODE_LINE: begin
				if (c == cssf_pkg::CH_NEWLINE) j.mode = cssf_pkg::MODE_TEXT;
				else j.keep = 1'b0;
			end
			cssf_pkg::MODE_BLOCK: begin
				j.keep = 1'b0;
				if (prev == cssf_pkg::CH_STAR && c == cssf_pkg::CH_SLASH)
					j.mode = cssf_pkg::MODE_TEXT;
			end
			default: begin
				if (c == cssf_pkg::CH_QUOTE) begin
					j.mode = cssf_pkg::MODE_STRING;
				end else if (has_next && c == cssf_pkg::CH_SLASH
						&& nxt == cssf_pkg::CH_SLASH) begin
					j.mode = cssf_pkg::MODE_LINE;
					j.keep = 1'b0;
				end else if (has_next && c == cssf_pkg::CH_SLASH
						&& nxt == cssf_pkg::CH_STAR) begin
					j.mode = cssf_pkg::MODE_BLOCK;
					j.keep = 1'b0;
				end
			end
		endcase
		return j;
	endfunction

	judge_t          jh;
	judge_t          jb;
	cssf_pkg::mode_t mode_h;
	logic [7:0]      prev_b;
	logic            keep_a;
	logic            keep_b;
	logic            bare;
	logic            unclosed;

	// Judge the held byte, then the final byte with no follower
	always_comb begin
		jh     = judge(state.mode, state.held_char, state.char_before_held, 1'b1, in_byte);
		mode_h = state.held_present ? jh.mode : state.mode;
		prev_b = state.held_present ? state.held_char : state.char_before_held;
		jb     = judge(mode_h, in_byte, prev_b, 1'b0, 8'h00);
	end

	// Build the result items
	always_comb begin
		keep_a   = state.held_present && jh.keep;
		keep_b   = in_last && jb.keep;
		bare     = in_last && !keep_a && !keep_b;
		unclosed = (jb.mode == cssf_pkg::MODE_LINE) || (jb.mode == cssf_pkg::MODE_BLOCK);

		push.push_a = keep_a;
		push.push_b = keep_b || bare;

		res_a.out_byte         = state.held_char;
		res_a.byte_valid       = 1'b1;
		res_a.out_last         = in_last && !keep_b;
		res_a.unclosed_comment = in_last && !keep_b && unclosed;

		res_b.out_byte         = keep_b ? in_byte : 8'h00;
		res_b.byte_valid       = keep_b;
		res_b.out_last         = 1'b1;
		res_b.unclosed_comment = unclosed;
	end

	// Advance the state, or return to reset at the end of a text
	always_comb begin
		if (in_last) begin
			state_next.mode             = cssf_pkg::MODE_TEXT;
			state_next.held_char        = 8'h00;
			state_next.held_present     = 1'b0;
			state_next.char_before_held = 8'h00;
		end else begin
			state_next.mode             = mode_h;
			state_next.held_char        = in_byte;
			state_next.held_present     = 1'b1;
			state_next.char_before_held = prev_b;
		end
	end

endmodule

>>> hdl/cssf_res_queue.sv
// ----------------------------------------------------------------------------
// cssf_res_queue
// Small result queue: takes up to two results a cycle, gives one a cycle on pop.
// ----------------------------------------------------------------------------
module cssf_res_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cssf_pkg::push_t         push,
	input  cssf_pkg::result_t       res_a,
	input  cssf_pkg::result_t       res_b,
	input  logic                    pop,
	output cssf_pkg::result_t       head,
	output cssf_pkg::queue_status_t status
);

	cssf_pkg::result_t            mem_q [cssf_pkg::QDEPTH];
	logic [cssf_pkg::QAW-1:0]     wptr_q;
	logic [cssf_pkg::QAW-1:0]     rptr_q;
	logic [cssf_pkg::QCW-1:0]     cnt_q;
	logic [cssf_pkg::QCW-1:0]     n_push;
	logic [cssf_pkg::QCW-1:0]     n_pop;
	logic [cssf_pkg::QAW-1:0]     wptr_p1;
	cssf_pkg::result_t            first;

	// Pack the pushed results in order
	always_comb begin
		n_push  = cssf_pkg::QCW'(push.push_a) + cssf_pkg::QCW'(push.push_b);
		n_pop   = cssf_pkg::QCW'(pop);
		first   = push.push_a ? res_a : res_b;
		wptr_p1 = wptr_q + cssf_pkg::QAW'(1);
	end

	// Store results
	always_ff @(posedge clk) begin
		if (push.push_a || push.push_b) mem_q[wptr_q] <= first;
		if (push.push_a && push.push_b) mem_q[wptr_p1] <= res_b;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + n_push[cssf_pkg::QAW-1:0];
			rptr_q <= rptr_q + n_pop[cssf_pkg::QAW-1:0];
			cnt_q  <= cnt_q + n_push - n_pop;
		end
	end

	assign head             = mem_q[rptr_q];
	assign status.not_empty = (cnt_q != '0);
	assign status.room2     = (cnt_q <= cssf_pkg::QCW'(cssf_pkg::QDEPTH - 2));

endmodule

>>> hdl/comment_strip_filter.sv
// ----------------------------------------------------------------------------
// comment_strip_filter
// Drops line and block comments from a byte stream, keeps string literals.
// ----------------------------------------------------------------------------
// One input byte is taken per clock while s_tready is high. Each byte is
// judged when the next one arrives, so a kept byte appears one transfer
// later; the byte marked last flushes the held byte and itself, and its
// final result carries tlast and the unclosed-comment flag. An accepted
// byte yields zero, one or two results, written in the same cycle into a
// four-entry result queue that drains one transfer per cycle while the
// output side is ready; the input side is ready while the queue has two
// free entries, so the block then sustains one byte per cycle.
// A slash-star-slash sequence opens and closes a block comment at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module comment_strip_filter (
	input  logic       clk,
	input  logic       arst_n,
	// slave side
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	// master side
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [0] byte_valid, [1] unclosed_comment
	output logic       m_tlast    // out_last
);

	cssf_pkg::scan_state_t   state_q;
	cssf_pkg::scan_state_t   state_next;
	cssf_pkg::push_t         push_raw;
	cssf_pkg::push_t         push;
	cssf_pkg::result_t       res_a;
	cssf_pkg::result_t       res_b;
	cssf_pkg::result_t       head;
	cssf_pkg::queue_status_t qstat;
	logic                    s_xfer;

	assign s_tready = qstat.room2;
	assign s_xfer   = s_tvalid && s_tready;

	// Judge the incoming byte
	cssf_scan u_scan (
		.state      (state_q),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.state_next (state_next),
		.push       (push_raw),
		.res_a      (res_a),
		.res_b      (res_b)
	);

	// Update the scanner state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode             <= cssf_pkg::MODE_TEXT;
			state_q.held_char        <= 8'h00;
			state_q.held_present     <= 1'b0;
			state_q.char_before_held <= 8'h00;
		end else if (s_xfer) begin
			state_q <= state_next;
		end
	end

	// Gate queue writes by the transfer
	always_comb begin
		push.push_a = push_raw.push_a && s_xfer;
		push.push_b = push_raw.push_b && s_xfer;
	end

	cssf_res_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res_a  (res_a),
		.res_b  (res_b),
		.pop    (m_tvalid && m_tready),
		.head   (head),
		.status (qstat)
	);

	// Drive the master side from the queue head
	assign m_tvalid   = qstat.not_empty;
	assign m_tdata    = head.out_byte;
	assign m_tuser[0] = head.byte_valid;
	assign m_tuser[1] = head.unclosed_comment;
	assign m_tlast    = head.out_last;

	`ASSERT_IMPLY(a_bare_is_last, m_tvalid && !m_tuser[0], m_tlast, "bare marker without tlast")
	`ASSERT_IMPLY(a_unclosed_is_last, m_tvalid && m_tuser[1], m_tlast, "unclosed flag before end")
	`ASSERT_NEXT(a_last_clears, s_xfer && s_tlast, !state_q.held_present, "held byte after end")
	`ASSERT_IMPLY(a_stall_has_data, !s_tready, m_tvalid, "input stalled with empty queue")

endmodule

>>> tb/sv/comment_strip_filter_tb.sv
// ----------------------------------------------------------------------------
// comment_strip_filter_tb
// Self-checking bench for the comment strip filter. Byte streams made of
// code-like fragments (comments, strings, stray slashes and stars, raw bytes)
// are pushed through the slave side under random idling. A scoreboard models
// the scan in step with each accepted byte. It checks every master-side
// transfer, in order, against the kept characters and end markers it expects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module comment_strip_filter_tb;

	// Tracks the scan state and the results still owed by the block
	class strip_scoreboard;
		cssf_pkg::mode_t   mode;
		logic [7:0]        pending_char;
		logic              pending_ok;
		logic [7:0]        char_prior;
		cssf_pkg::result_t kept_chars[$];
		int                mismatches;

		function new();
			mismatches = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			mode = cssf_pkg::MODE_TEXT;
			pending_char = 8'h00;
			pending_ok = 1'b0;
			char_prior = 8'h00;
		endfunction

		function int unsigned owed();
			return kept_chars.size();
		endfunction

		// Append one expected result behind the others
		function void owe_result(cssf_pkg::result_t r);
			kept_chars = {kept_chars, r};
		endfunction

		task report(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		// Decide whether c survives; a slash may look at the byte after it
		function bit keeps_char(logic [7:0] c, logic [7:0] prior, bit has_next,
				logic [7:0] next_c);
			case (mode)
				cssf_pkg::MODE_STRING: begin
					if (c == cssf_pkg::CH_QUOTE)
						mode = cssf_pkg::MODE_TEXT;
					return 1'b1;
				end
				cssf_pkg::MODE_LINE: begin
					if (c == cssf_pkg::CH_NEWLINE) begin
						mode = cssf_pkg::MODE_TEXT;
						return 1'b1;
					end
					return 1'b0;
				end
				cssf_pkg::MODE_BLOCK: begin
					// closing slash may share its star with the opening one
					if (prior == cssf_pkg::CH_STAR && c == cssf_pkg::CH_SLASH)
						mode = cssf_pkg::MODE_TEXT;
					return 1'b0;
				end
				default: begin
					if (c == cssf_pkg::CH_QUOTE) begin
						mode = cssf_pkg::MODE_STRING;
						return 1'b1;
					end
					if (has_next && c == cssf_pkg::CH_SLASH
							&& next_c == cssf_pkg::CH_SLASH) begin
						mode = cssf_pkg::MODE_LINE;
						return 1'b0;
					end
					if (has_next && c == cssf_pkg::CH_SLASH
							&& next_c == cssf_pkg::CH_STAR) begin
						mode = cssf_pkg::MODE_BLOCK;
						return 1'b0;
					end
					return 1'b1;
				end
			endcase
		endfunction

		// Note one accepted input transfer and queue what it should produce
		function void note_byte(logic [7:0] b, logic last);
			cssf_pkg::result_t staged[2];
			int                n;
			n = 0;
			if (pending_ok) begin
				if (keeps_char(pending_char, char_prior, 1'b1, b)) begin
					staged[n] = '{out_byte: pending_char, byte_valid: 1'b1,
						out_last: 1'b0, unclosed_comment: 1'b0};
					n++;
				end
				char_prior = pending_char;
			end
			if (!last) begin
				pending_char = b;
				pending_ok = 1'b1;
			end else begin
				// final byte has no follower, so a slash here is plain text
				if (keeps_char(b, char_prior, 1'b0, 8'h00)) begin
					staged[n] = '{out_byte: b, byte_valid: 1'b1,
						out_last: 1'b0, unclosed_comment: 1'b0};
					n++;
				end
				if (n == 0) begin
					staged[0] = '{out_byte: 8'h00, byte_valid: 1'b0,
						out_last: 1'b0, unclosed_comment: 1'b0};
					n = 1;
				end
				staged[n-1].out_last = 1'b1;
				staged[n-1].unclosed_comment = (mode == cssf_pkg::MODE_LINE
					|| mode == cssf_pkg::MODE_BLOCK);
				clear_scan();
			end
			for (int i = 0; i < n; i++)
				owe_result(staged[i]);
		endfunction

		// Compare one output transfer with the oldest expectation
		task check_result(logic [7:0] data, logic [1:0] user, logic last);
			cssf_pkg::result_t want;
			if (kept_chars.size() == 0) begin
				report($sformatf("output %02h user %b last %b with nothing expected",
					data, user, last));
				return;
			end
			want = kept_chars.pop_front();
			if (data !== want.out_byte)
				report($sformatf("out_byte got %02h want %02h", data, want.out_byte));
			if (user[0] !== want.byte_valid)
				report($sformatf("byte_valid got %b want %b", user[0], want.byte_valid));
			if (last !== want.out_last)
				report($sformatf("out_last got %b want %b", last, want.out_last));
			if (user[1] !== want.unclosed_comment)
				report($sformatf("unclosed_comment got %b want %b", user[1],
					want.unclosed_comment));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	strip_scoreboard sb;
	logic [7:0]      text_q[$];
	bit              tx_idle;
	bit              rx_idle;
	bit              hold_req;

	comment_strip_filter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Append one character to the text being built
	function void append_char(logic [7:0] c);
		text_q = {text_q, c};
	endfunction

	// Idle length: mostly none or short, now and then long
	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Character for comment and string bodies, biased toward the steering ones
	function logic [7:0] body_char();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0: return cssf_pkg::CH_STAR;
			1: return cssf_pkg::CH_SLASH;
			2: return cssf_pkg::CH_QUOTE;
			3: return cssf_pkg::CH_NEWLINE;
			4, 5: return 8'($urandom_range(0, 255));
			6: return 8'h20;
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// Offer one byte, hold it until the transfer, then idle at random
	task send_byte(logic [7:0] b, logic last);
		int g;
		s_tdata = b;
		s_tlast = last;
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_byte(b, last);
		@(negedge clk);
		g = tx_idle ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task send_str(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task wait_drained();
		s_tvalid = 1'b0;
		while (sb.owed() != 0)
			@(negedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int g;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				g = 300;
				hold_req = 1'b0;
			end else begin
				g = rx_idle ? gap_len() : 0;
			end
			if (g > 0) begin
				m_tready = 1'b0;
				repeat (g) @(negedge clk);
			end
			m_tready = 1'b1;
			@(negedge clk);
		end
	end

	// Check every output transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	// Main stimulus
	initial begin
		int  sent;
		int  n_pieces;
		int  kind;
		int  len;
		bit  held_off;
		bit  paused;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		sent = 0;
		held_off = 1'b0;
		paused = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: nul and all-ones bytes, slash as final byte, unclosed
		// comments, slash-star-slash, comment markers inside a string
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(cssf_pkg::CH_SLASH, 1'b1);
		send_str("//x");
		send_str("/*/");
		send_str("/*a");
		send_str("\"//\"");
		send_str("//\n");
		send_str("/");
		send_str("/*a*/");
		wait_drained();

		// Random texts built from code-like fragments
		while (sent < 1800) begin
			text_q.delete();
			n_pieces = $urandom_range(1, 6);
			repeat (n_pieces) begin
				kind = $urandom_range(0, 99);
				len = $urandom_range(0, 6);
				if (kind < 25) begin
					repeat (len + 1) append_char(body_char());
				end else if (kind < 45) begin
					append_char(cssf_pkg::CH_SLASH);
					append_char(cssf_pkg::CH_SLASH);
					repeat (len) append_char(body_char());
					if ($urandom_range(0, 4) != 0)
						append_char(cssf_pkg::CH_NEWLINE);
				end else if (kind < 65) begin
					append_char(cssf_pkg::CH_SLASH);
					append_char(cssf_pkg::CH_STAR);
					repeat (len) append_char(body_char());
					if ($urandom_range(0, 4) != 0) begin
						append_char(cssf_pkg::CH_STAR);
						append_char(cssf_pkg::CH_SLASH);
					end
				end else if (kind < 80) begin
					append_char(cssf_pkg::CH_QUOTE);
					repeat (len) append_char(body_char());
					if ($urandom_range(0, 4) != 0)
						append_char(cssf_pkg::CH_QUOTE);
				end else if (kind < 90) begin
					case ($urandom_range(0, 3))
						0: append_char(cssf_pkg::CH_SLASH);
						1: append_char(cssf_pkg::CH_STAR);
						2: append_char(cssf_pkg::CH_NEWLINE);
						default: append_char(cssf_pkg::CH_QUOTE);
					endcase
				end else begin
					repeat (len + 1) append_char(8'($urandom_range(0, 255)));
				end
			end
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			// stall the output for a long stretch while input keeps coming
			if (!held_off && sent >= 600) begin
				hold_req = 1'b1;
				held_off = 1'b1;
				tx_idle = 1'b0;
			end
			// let the block drain completely once mid-run
			if (!paused && sent >= 1200) begin
				wait_drained();
				paused = 1'b1;
			end
			foreach (text_q[i])
				send_byte(text_q[i], i == text_q.size() - 1);
			sent += text_q.size();
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (sb.mismatches == 0 && sb.owed() == 0) begin
			$display("comment_strip_filter_tb passed");
		end else begin
			$display("comment_strip_filter_tb failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("comment_strip_filter_tb failed");
		$finish;
	end

endmodule
